FILE: hdl/flsm_pkg.sv
// Package for the five-level lock set manager: lock levels, request kinds,
// field widths, result bit positions and parameter defaults.
// No dependencies; imported by the top level and its checker.
package flsm_pkg;

  localparam int unsigned READER_SLOTS_DEF = 16;
  localparam int unsigned ID_BITS_DEF      = 16;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned RESULT_W  = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd30000;

  // Lock levels.
  localparam logic [LEVEL_W-1:0] LV_NONE      = 3'd0;
  localparam logic [LEVEL_W-1:0] LV_SHARED    = 3'd1;
  localparam logic [LEVEL_W-1:0] LV_RESERVED  = 3'd2;
  localparam logic [LEVEL_W-1:0] LV_PENDING   = 3'd3;
  localparam logic [LEVEL_W-1:0] LV_EXCLUSIVE = 3'd4;

  // Request kinds carried in tuser.
  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  // Bit positions in the result word.
  localparam int unsigned RES_GRANTED     = 0;
  localparam int unsigned RES_CHANGED     = 1;
  localparam int unsigned RES_WRITER_HELD = 2;
  localparam int unsigned RES_TABLE_FULL  = 3;

endpackage

FILE: hdl/five_level_lock_set_manager_top.sv
// A request word passes the writer check, a scan of the reader table and a decision before its
// result is registered; no new request is accepted until the decision is taken. The reader
// table is walked one slot per cycle through a single expiry adder and compare.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_ni low, asynchronous) empties the reader table and the writer lock and
// loads the expiry timeout with 30000; owner and stamp storage is not cleared.
//
// Five-level lock set manager: one lock set shared by many clients.
// Depends on flsm_pkg.
module five_level_lock_set_manager_top
  import flsm_pkg::*;
#(
  parameter int unsigned READER_SLOTS = READER_SLOTS_DEF,
  parameter int unsigned ID_BITS      = ID_BITS_DEF,
  localparam int unsigned IN_W        = ((ID_BITS + LEVEL_W + TIME_W + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_wdata_i,     // expiry timeout
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_W-1:0]      s_axis_tdata_i,  // client_id, target_level, now_time, zero pad
  input  logic                 s_axis_tuser_i,  // req_type
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [RESULT_W-1:0]  m_axis_tdata_o   // granted, changed, writer_held, table_full
);

  localparam int unsigned IDX_W = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WCHK,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e                  state_q;
  logic [TIMEOUT_W-1:0]    timeout_q;
  logic [READER_SLOTS-1:0] reader_valid_q;
  logic                    writer_valid_q;
  logic [ID_BITS-1:0]      writer_owner_q;
  logic [LEVEL_W-1:0]      writer_level_q;
  logic [TIME_W-1:0]       writer_stamp_q;

  logic [ID_BITS-1:0]      owner_mem [READER_SLOTS];
  logic [TIME_W-1:0]       stamp_mem [READER_SLOTS];
  logic [ID_BITS-1:0]      rd_owner_q;
  logic [TIME_W-1:0]       rd_stamp_q;
  logic [IDX_W-1:0]        rd_addr;

  logic                    unlock_q;
  logic [ID_BITS-1:0]      id_q;
  logic [LEVEL_W-1:0]      tgt_q;
  logic [TIME_W-1:0]       now_q;

  logic [IDX_W-1:0]        idx_q;
  logic                    idx_last;
  logic [READER_SLOTS-1:0] surv_q;
  logic [READER_SLOTS-1:0] match_q;
  logic                    mine_rd_q;
  logic                    others_q;
  logic                    found_q;
  logic [IDX_W-1:0]        free_q;
  logic                    wsurv_q;
  logic                    wown_q;
  logic                    wmatch_q;

  logic                    out_valid_q;
  logic [RESULT_W-1:0]     out_data_q;

  // Shared expiry unit: stamp + timeout <= now.
  logic [TIME_W-1:0]       cmp_stamp;
  logic [TIME_W:0]         cmp_sum;
  logic                    cmp_expired;

  // Per-slot view during the scan.
  logic                    slot_valid;
  logic                    slot_own;
  logic                    slot_surv;
  logic                    slot_busy;

  // Decision.
  logic [LEVEL_W-1:0]      mine;
  logic                    sat;
  logic                    fw;
  logic                    d_granted;
  logic                    d_changed;
  logic                    d_full;
  logic                    d_add;
  logic                    d_set_w;
  logic [LEVEL_W-1:0]      d_wlevel;
  logic [READER_SLOTS-1:0] d_rv;
  logic                    d_wv;
  logic [RESULT_W-1:0]     d_result;
  logic                    proceed;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign cmp_stamp   = (state_q == S_WCHK) ? writer_stamp_q : rd_stamp_q;
  assign cmp_sum     = {1'b0, cmp_stamp} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, timeout_q};
  assign cmp_expired = (cmp_sum <= {1'b0, now_q});

  assign idx_last   = (idx_q == IDX_W'(READER_SLOTS - 1));
  assign slot_valid = reader_valid_q[idx_q];
  assign slot_own   = (rd_owner_q == id_q);
  assign slot_surv  = slot_valid & ~cmp_expired;
  // A slot stays occupied after purge and after the client's own entries are dropped.
  assign slot_busy  = slot_surv & ~slot_own;

  // The read for slot i+1 is issued while slot i is evaluated.
  always_comb begin
    rd_addr = '0;
    if (state_q == S_SCAN && !idx_last) begin
      rd_addr = idx_q + IDX_W'(1);
    end
  end

  assign proceed = (state_q == S_DECIDE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    mine      = wmatch_q ? writer_level_q : (mine_rd_q ? LV_SHARED : LV_NONE);
    sat       = unlock_q ? (mine <= tgt_q) : (mine >= tgt_q);
    fw        = wsurv_q & ~wown_q;
    d_granted = 1'b0;
    d_changed = 1'b0;
    d_full    = 1'b0;
    d_add     = 1'b0;
    d_set_w   = 1'b0;
    d_wlevel  = tgt_q;
    d_rv      = surv_q;
    d_wv      = wsurv_q;
    if (sat) begin
      // Nothing changes and no purge is done.
      d_granted = 1'b1;
      d_rv      = reader_valid_q;
      d_wv      = writer_valid_q;
    end else if (unlock_q == REQ_LOCK) begin
      case (tgt_q)
        LV_SHARED: begin
          if (!wsurv_q || writer_level_q == LV_RESERVED) begin
            if (found_q) begin
              d_add     = 1'b1;
              d_granted = 1'b1;
              d_changed = 1'b1;
            end else begin
              d_full = 1'b1;
            end
          end
        end
        LV_RESERVED, LV_PENDING: begin
          if (!fw) begin
            d_rv      = surv_q & ~match_q;
            d_set_w   = 1'b1;
            d_granted = 1'b1;
            d_changed = 1'b1;
          end
        end
        LV_EXCLUSIVE: begin
          // A pending holder that still sees other readers keeps its pending lock.
          if (!fw && !(others_q && mine == LV_PENDING)) begin
            d_rv      = surv_q & ~match_q;
            d_set_w   = 1'b1;
            d_wlevel  = others_q ? LV_PENDING : LV_EXCLUSIVE;
            d_granted = ~others_q;
            d_changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (tgt_q)
        LV_NONE: begin
          d_rv      = surv_q & ~match_q;
          d_wv      = fw;
          d_granted = 1'b1;
          d_changed = 1'b1;
        end
        LV_SHARED: begin
          d_rv      = surv_q & ~match_q;
          d_wv      = fw;
          d_changed = 1'b1;
          if (!fw) begin
            if (found_q) begin
              d_add     = 1'b1;
              d_granted = 1'b1;
            end else begin
              d_full = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (d_add) begin
      d_rv[free_q] = 1'b1;
    end
    if (d_set_w) begin
      d_wv = 1'b1;
    end
    d_result                  = '0;
    d_result[RES_GRANTED]     = d_granted;
    d_result[RES_CHANGED]     = d_changed;
    d_result[RES_WRITER_HELD] = d_wv;
    d_result[RES_TABLE_FULL]  = d_full;
  end

  // Owner and stamp storage for the reader table.
  always_ff @(posedge clk_i) begin
    if (proceed && d_add) begin
      owner_mem[free_q] <= id_q;
      stamp_mem[free_q] <= now_q;
    end
    rd_owner_q <= owner_mem[rd_addr];
    rd_stamp_q <= stamp_mem[rd_addr];
  end

  // Request and writer payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      unlock_q <= s_axis_tuser_i;
      id_q     <= s_axis_tdata_i[ID_BITS-1:0];
      tgt_q    <= s_axis_tdata_i[ID_BITS +: LEVEL_W];
      now_q    <= s_axis_tdata_i[ID_BITS + LEVEL_W +: TIME_W];
    end
    if (state_q == S_WCHK) begin
      wown_q <= (writer_owner_q == id_q);
    end
    if (proceed && d_set_w) begin
      writer_owner_q <= id_q;
      writer_level_q <= d_wlevel;
      writer_stamp_q <= now_q;
    end
    if (state_q == S_SCAN) begin
      surv_q[idx_q]  <= slot_surv;
      match_q[idx_q] <= slot_own;
      if (!found_q && !slot_busy) begin
        free_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      timeout_q      <= TIMEOUT_RESET;
      reader_valid_q <= '0;
      writer_valid_q <= 1'b0;
      idx_q          <= '0;
      mine_rd_q      <= 1'b0;
      others_q       <= 1'b0;
      found_q        <= 1'b0;
      wsurv_q        <= 1'b0;
      wmatch_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (proceed) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            idx_q   <= '0;
            state_q <= S_WCHK;
          end
        end
        S_WCHK: begin
          wsurv_q   <= writer_valid_q & ~cmp_expired;
          wmatch_q  <= writer_valid_q & (writer_owner_q == id_q);
          mine_rd_q <= 1'b0;
          others_q  <= 1'b0;
          found_q   <= 1'b0;
          state_q   <= S_SCAN;
        end
        S_SCAN: begin
          if (slot_valid && slot_own) begin
            mine_rd_q <= 1'b1;
          end
          if (slot_busy) begin
            others_q <= 1'b1;
          end else begin
            found_q <= 1'b1;
          end
          if (idx_last) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          if (proceed) begin
            reader_valid_q <= d_rv;
            writer_valid_q <= d_wv;
            out_data_q     <= d_result;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/flsm_checker.sv
// Port-level checker for the five-level lock set manager, bound to the top level.
// Depends on flsm_pkg and five_level_lock_set_manager_top.
module flsm_checker
  import flsm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_i,
  input logic                m_axis_tvalid_i,
  input logic                m_axis_tready_i,
  input logic [RESULT_W-1:0] m_axis_tdata_i
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_i;

  // A request occupies the block: the input stays not ready after a word is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_i ##1 !s_axis_tready_i)
    else $error("input accepted again too soon after a request word");

  // No result can appear in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid_i))
    else $error("result appeared one cycle after acceptance");

  // A refusal for lack of a reader slot is never a grant.
  a_full_not_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(m_axis_tdata_i[RES_TABLE_FULL] && m_axis_tdata_i[RES_GRANTED]))
    else $error("table_full and granted both set");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("stalled result word changed");

endmodule

bind five_level_lock_set_manager_top flsm_checker u_flsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
